// ----- sv/sps_pkg.sv -----
`default_nettype none

package sps_pkg;

    // Field widths
    localparam int MODE_W     = 2;
    localparam int TICK_W     = 16;
    localparam int PHASE_W    = 3;
    localparam int COIL_W     = 4;
    localparam int OP_W       = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    // Command codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_ABORT = 2'd2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_TICKS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OFF_TICKS  = 2'd2;

    // Phase table selection
    localparam logic [MODE_W-1:0] MODE_HALF4 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FULL4 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HALF3 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FULL3 = 2'd3;

    // Register reset values
    localparam logic [TICK_W-1:0] STEP_TICKS_RST = 16'd100;

    // Coil patterns, entry 0 first
    localparam logic [COIL_W-1:0] HALF4_PAT [8] = '{4'd1, 4'd3, 4'd2, 4'd6,
                                                    4'd4, 4'd12, 4'd8, 4'd9};
    localparam logic [COIL_W-1:0] FULL4_PAT [4] = '{4'd1, 4'd2, 4'd4, 4'd8};
    localparam logic [COIL_W-1:0] HALF3_PAT [6] = '{4'd1, 4'd3, 4'd2, 4'd6,
                                                    4'd4, 4'd5};

    // Highest phase index of each table
    function automatic logic [PHASE_W-1:0] phase_last(input logic [MODE_W-1:0] m);
        logic [PHASE_W-1:0] last;
        unique case (m)
            MODE_HALF4: last = 3'd7;
            MODE_FULL4: last = 3'd3;
            MODE_HALF3: last = 3'd5;
            MODE_FULL3: last = 3'd2;
            default:    last = 3'd7;
        endcase
        return last;
    endfunction

    // Coil pattern for a phase; in half3 and full3 an index beyond the table reads entry 0, full4 uses the low two bits
    function automatic logic [COIL_W-1:0] coil_lookup(input logic [MODE_W-1:0]  m,
                                                      input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] pat;
        unique case (m)
            MODE_HALF4: pat = HALF4_PAT[ph];
            MODE_FULL4: pat = FULL4_PAT[ph[1:0]];
            MODE_HALF3: pat = (ph < 3'd6) ? HALF3_PAT[ph] : HALF3_PAT[0];
            MODE_FULL3: pat = (ph < 3'd3) ? FULL4_PAT[ph[1:0]] : FULL4_PAT[0];
            default:    pat = '0;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ----- sv/stepper_phase_sequencer.sv -----
`default_nettype none

// A result passes the input register and then the result register before m_tvalid rises;
// while the result register is stalled, the next item waits in the input register.
// Throughput: one item per cycle while m_tready is high; the sequencer state is updated once per item.
// Reset (rst_n low, asynchronous): coils off, phase 0, no run; mode 0 (half4),
// step_ticks 100, off_ticks 0; both pipeline registers empty.
module stepper_phase_sequencer
    import sps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Command stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] step_count, [16] reverse, [23:17] zero
    input  wire logic [OP_W-1:0]       s_tuser,   // [1:0] opcode
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata    // [3:0] coils, [4] busy_res, [7:5] phase,
                                                  // [8] done_res, [15:9] zero
);

    // Configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [TICK_W-1:0] step_ticks_reg;
    logic [TICK_W-1:0] off_ticks_reg;

    // Input register
    logic              in_valid_reg;
    logic [OP_W-1:0]   in_op_reg;
    logic [TICK_W-1:0] in_count_reg;
    logic              in_rev_reg;

    // Sequencer state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TICK_W-1:0]  steps_left_reg, steps_left_next;
    logic [TICK_W-1:0]  tick_counter_reg, tick_counter_next;
    logic               in_off_reg, in_off_next;
    logic               running_reg, running_next;
    logic               backwards_reg, backwards_next;
    logic [COIL_W-1:0]  coil_reg, coil_next;
    logic               done_next;

    // Result register
    logic               out_valid_reg;
    logic               out_done_reg;

    logic               proc_fire;
    logic               in_fire;
    logic [PHASE_W-1:0] last_ph;
    logic [PHASE_W-1:0] ph_fix;
    logic [PHASE_W-1:0] ph_adv;
    logic [TICK_W-1:0]  steps_dec;
    logic [TICK_W-1:0]  tick_inc;
    logic [TICK_W-1:0]  hold_lim;
    logic               do_advance;

    // Handshake: process when the result register is free or being drained
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign in_fire   = s_tvalid && s_tready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_HALF4;
            step_ticks_reg <= STEP_TICKS_RST;
            off_ticks_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_MODE:       mode_reg       <= cfg_wdata[MODE_W-1:0];
                REG_STEP_TICKS: step_ticks_reg <= cfg_wdata[TICK_W-1:0];
                REG_OFF_TICKS:  off_ticks_reg  <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the incoming transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_op_reg    <= s_tuser;
            in_count_reg <= s_tdata[TICK_W-1:0];
            in_rev_reg   <= s_tdata[TICK_W];
        end
    end

    // Phase arithmetic shared by start and advance
    always_comb
    begin
        last_ph   = phase_last(mode_reg);
        ph_fix    = (phase_reg > last_ph) ? '0 : phase_reg;
        if (backwards_reg)
            ph_adv = (ph_fix == '0) ? last_ph : ph_fix - 3'd1;
        else
            ph_adv = (ph_fix == last_ph) ? '0 : ph_fix + 3'd1;
        steps_dec = steps_left_reg - 16'd1;
        tick_inc  = tick_counter_reg + 16'd1;
        hold_lim  = (step_ticks_reg == '0) ? 16'd1 : step_ticks_reg;
    end

    // Decode the command and work out the next state
    always_comb
    begin
        phase_next        = phase_reg;
        steps_left_next   = steps_left_reg;
        tick_counter_next = tick_counter_reg;
        in_off_next       = in_off_reg;
        running_next      = running_reg;
        backwards_next    = backwards_reg;
        coil_next         = coil_reg;
        done_next         = 1'b0;
        do_advance        = 1'b0;

        unique case (in_op_reg)
            OP_START:
            begin
                tick_counter_next = '0;
                in_off_next       = 1'b0;
                if (in_count_reg == '0)
                begin
                    done_next       = running_reg;
                    running_next    = 1'b0;
                    coil_next       = '0;
                    phase_next      = '0;
                    steps_left_next = '0;
                end
                else
                begin
                    phase_next      = ph_fix;
                    backwards_next  = in_rev_reg;
                    steps_left_next = in_count_reg;
                    running_next    = 1'b1;
                    coil_next       = coil_lookup(mode_reg, ph_fix);
                end
            end
            OP_ABORT:
            begin
                done_next         = running_reg;
                running_next      = 1'b0;
                steps_left_next   = '0;
                tick_counter_next = '0;
                in_off_next       = 1'b0;
            end
            OP_TICK:
            begin
                if (running_reg)
                begin
                    tick_counter_next = tick_inc;
                    if (!in_off_reg)
                    begin
                        if (tick_inc >= hold_lim)
                        begin
                            if (off_ticks_reg != '0)
                            begin
                                coil_next         = '0;
                                in_off_next       = 1'b1;
                                tick_counter_next = '0;
                            end
                            else
                            begin
                                do_advance = 1'b1;
                            end
                        end
                    end
                    else if (tick_inc >= off_ticks_reg)
                    begin
                        do_advance = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // Step to the next phase; the last step ends the run
        if (do_advance)
        begin
            phase_next        = ph_adv;
            steps_left_next   = steps_dec;
            tick_counter_next = '0;
            in_off_next       = 1'b0;
            if (steps_dec == '0)
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
            else
            begin
                coil_next = coil_lookup(mode_reg, ph_adv);
            end
        end
    end

    // Commit the state once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= '0;
            steps_left_reg   <= '0;
            tick_counter_reg <= '0;
            in_off_reg       <= 1'b0;
            running_reg      <= 1'b0;
            backwards_reg    <= 1'b0;
            coil_reg         <= '0;
        end
        else if (proc_fire)
        begin
            phase_reg        <= phase_next;
            steps_left_reg   <= steps_left_next;
            tick_counter_reg <= tick_counter_next;
            in_off_reg       <= in_off_next;
            running_reg      <= running_next;
            backwards_reg    <= backwards_next;
            coil_reg         <= coil_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            out_done_reg <= done_next;
        end
    end

    // The state registers double as the result payload
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_done_reg, phase_reg, running_reg, coil_reg};

    // A finished run never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> !running_reg)
        else $error("done reported while still running");

    // A run always has steps left
    a_running_steps: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> steps_left_reg != '0)
        else $error("running with no steps left");

    // Off period only within a run
    a_off_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_off_reg |-> running_reg)
        else $error("off period outside a run");

    // Idle keeps the tick counter clear
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> tick_counter_reg == '0)
        else $error("tick counter moved while idle");

    // A start with a non-zero count begins a run
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_op_reg == OP_START && in_count_reg != '0 |=> running_reg)
        else $error("start did not begin a run");

endmodule

`default_nettype wire
